@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Every assertion samples on the rising edge of clk and is off while rst_n is low.

`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tft_pkg.sv @@
`default_nettype none

package tft_pkg;

    localparam int DEPTH   = 5;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 3;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef value_t [DEPTH-1:0] slots_t;

    localparam value_t EMPTY_READ = 16'hFFFF;
    localparam count_t FULL_COUNT = COUNT_W'(DEPTH);

    typedef struct packed {
        logic   clear;
        value_t new_value;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/tft_if.sv @@
`default_nettype none

interface tft_sample_if
    import tft_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   clear;
    value_t new_value;

    modport source (output valid, output clear, output new_value, input ready);
    modport sink (input valid, input clear, input new_value, output ready);
endinterface

interface tft_result_if
    import tft_pkg::*;
();
    logic   valid;
    logic   ready;
    count_t kept_count;
    value_t kept_0;
    value_t kept_1;
    value_t kept_2;
    value_t kept_3;
    value_t kept_4;

    modport source (
        output valid, output kept_count,
        output kept_0, output kept_1, output kept_2, output kept_3, output kept_4,
        input ready
    );
    modport sink (
        input valid, input kept_count,
        input kept_0, input kept_1, input kept_2, input kept_3, input kept_4,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/tft_update.sv @@
`default_nettype none

module tft_update
    import tft_pkg::*;
(
    input  wire item_t  item,
    input  wire count_t count,
    input  wire slots_t slots,
    output count_t      count_next,
    output slots_t      slots_next
);

    logic [DEPTH-1:0] held;
    logic [DEPTH-1:0] above;
    logic [DEPTH-1:0] below;
    logic             full;
    logic             evict;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            held[i]  = COUNT_W'(i) < count;
            above[i] = slots[i] > item.new_value;
            below[i] = slots[i] < item.new_value;
        end
        full  = (count >= FULL_COUNT);
        evict = below[0];
    end

    always_comb
    begin
        slots_next = slots;
        count_next = count;
        if (item.clear)
        begin
            slots_next = '0;
            count_next = '0;
        end
        else if (!full)
        begin
            // Sorted insert: larger held values move up one slot.
            for (int i = 0; i < DEPTH; i++)
            begin
                if (held[i] && !above[i])
                begin
                    slots_next[i] = slots[i];
                end
                else if (i == 0)
                begin
                    slots_next[i] = item.new_value;
                end
                else if (!above[i-1] || !held[i-1])
                begin
                    slots_next[i] = item.new_value;
                end
                else
                begin
                    slots_next[i] = slots[i-1];
                end
            end
            count_next = count + 1'b1;
        end
        else if (evict)
        begin
            // The smallest value drops out and smaller values move down one slot.
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (below[i+1])
                begin
                    slots_next[i] = slots[i+1];
                end
                else if (i == 0 || below[i])
                begin
                    slots_next[i] = item.new_value;
                end
                else
                begin
                    slots_next[i] = slots[i];
                end
            end
            slots_next[DEPTH-1] = below[DEPTH-1] ? item.new_value : slots[DEPTH-1];
        end
    end

endmodule

`default_nettype wire

@@ rtl/top_five_tracker.sv @@
// Top-five tracker: keeps the five largest 16-bit samples seen since the last clear.
// The sample channel carries clear and new_value; each transaction either empties
// the store (clear high, new_value ignored) or offers new_value to it.
// The result channel returns one transaction per sample transaction, in order:
// kept_count (0 to 5) and kept_0 to kept_4, the held values in ascending order,
// with every slot at or above kept_count reading 65535.
// A sample is registered in the input register; the sorted insert or replacement
// and the result are then computed combinationally and written to the result
// register, where result valid rises; a stalled receiver can hold the sample
// in the input register until the result register can take the result.
// Throughput is one sample per cycle while results are taken; the update is five
// parallel compares and a slot select, so consecutive samples see each other.
// When the receiver stalls, the result register holds and the input register
// still takes one more sample; sample.ready drops only when both are full.
// Reset empties the store, sets the count to zero and drops any pending
// transaction; the block takes samples in the first cycle after reset.
`default_nettype none

`include "assert_macros.svh"

module top_five_tracker
    import tft_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    tft_sample_if.sink    sample,
    tft_result_if.source  result
);

    item_t  item_reg;
    logic   item_valid_reg;
    count_t count_reg;
    slots_t slots_reg;
    count_t out_count_reg;
    slots_t kept_reg;
    logic   out_valid_reg;

    count_t count_next;
    slots_t slots_next;
    slots_t kept_next;
    logic   advance;
    logic   take;
    logic   sorted_ok;

    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = !item_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    tft_update u_update (
        .item       (item_reg),
        .count      (count_reg),
        .slots      (slots_reg),
        .count_next (count_next),
        .slots_next (slots_next)
    );

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            kept_next[i] = (COUNT_W'(i) < count_next) ? slots_next[i] : EMPTY_READ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
            slots_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (item_valid_reg && advance)
            begin
                count_reg     <= count_next;
                slots_reg     <= slots_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.clear     <= sample.clear;
            item_reg.new_value <= sample.new_value;
        end
        if (item_valid_reg && advance)
        begin
            out_count_reg <= count_next;
            kept_reg      <= kept_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.kept_count = out_count_reg;
    assign result.kept_0     = kept_reg[0];
    assign result.kept_1     = kept_reg[1];
    assign result.kept_2     = kept_reg[2];
    assign result.kept_3     = kept_reg[3];
    assign result.kept_4     = kept_reg[4];

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 1; i < DEPTH; i++)
        begin
            if (COUNT_W'(i) < count_reg && slots_reg[i-1] > slots_reg[i])
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_COUNT, "Held count exceeds five.")
    `ASSERT_ALWAYS(a_store_sorted, sorted_ok, "Held values are not in ascending order.")
    `ASSERT_NEXT(a_clear_empties, item_valid_reg && item_reg.clear && advance,
        count_reg == '0 && out_count_reg == '0 && out_valid_reg,
        "A clear did not empty the store.")

endmodule

`default_nettype wire

@@ test/top_five_tracker_tb.sv @@
`timescale 1ns / 100ps

module top_five_tracker_tb;
    import tft_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 312;
    localparam int PHASE_COUNT = 4;

    typedef struct {
        count_t kept_count;
        value_t kept [DEPTH];
    } store_view_t;

    logic clk = 1'b0;
    logic rst_n;

    tft_sample_if sample_bus ();
    tft_result_if result_bus ();

    top_five_tracker u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus)
    );

    item_t       pending_samples [$];
    store_view_t expected_views [$];
    value_t      shadow_slots [DEPTH];
    int          shadow_fill;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          error_count;
    int          quiet_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic store_view_t apply_sample(item_t s);
        store_view_t view;
        int          pos;
        if (s.clear)
        begin
            shadow_fill = 0;
            foreach (shadow_slots[k])
                shadow_slots[k] = '0;
        end
        else if (shadow_fill < DEPTH)
        begin
            pos = shadow_fill;
            while (pos > 0 && shadow_slots[pos-1] > s.new_value)
            begin
                shadow_slots[pos] = shadow_slots[pos-1];
                pos--;
            end
            shadow_slots[pos] = s.new_value;
            shadow_fill++;
        end
        else if (s.new_value > shadow_slots[0])
        begin
            pos = 0;
            while (pos < DEPTH - 1 && shadow_slots[pos+1] < s.new_value)
            begin
                shadow_slots[pos] = shadow_slots[pos+1];
                pos++;
            end
            shadow_slots[pos] = s.new_value;
        end
        view.kept_count = count_t'(shadow_fill);
        for (int k = 0; k < DEPTH; k++)
            view.kept[k] = (k < shadow_fill) ? shadow_slots[k] : EMPTY_READ;
        return view;
    endfunction

    function automatic item_t random_sample();
        item_t s;
        int    pick;
        s.clear = ($urandom_range(11) == 0);
        pick = $urandom_range(99);
        if (pick < 40)
            s.new_value = value_t'($urandom);
        else if (pick < 70)
            s.new_value = value_t'($urandom_range(15));
        else if (pick < 85)
            s.new_value = value_t'($urandom_range(65535, 65520));
        else
            s.new_value = $urandom_range(1) ? EMPTY_READ : '0;
        return s;
    endfunction

    task automatic push_sample(input logic clear, input value_t value);
        item_t s;
        s.clear = clear;
        s.new_value = value;
        pending_samples.push_back(s);
    endtask

    task automatic check_field(input string field, input value_t want, input value_t got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bus.valid <= 1'b0;
            sample_bus.clear <= 1'b0;
            sample_bus.new_value <= '0;
        end
        else
        begin
            if (sample_bus.valid && sample_bus.ready)
                expected_views.push_back(apply_sample(item_t'{sample_bus.clear,
                                                               sample_bus.new_value}));
            if (!sample_bus.valid || sample_bus.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    sample_bus.valid <= 1'b1;
                    sample_bus.clear <= pending_samples[0].clear;
                    sample_bus.new_value <= pending_samples[0].new_value;
                    void'(pending_samples.pop_front());
                end
                else
                begin
                    sample_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        store_view_t want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("result transaction with no expected result pending");
                    error_count++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    check_field("kept_count", value_t'(want.kept_count),
                                value_t'(result_bus.kept_count));
                    check_field("kept_0", want.kept[0], result_bus.kept_0);
                    check_field("kept_1", want.kept[1], result_bus.kept_1);
                    check_field("kept_2", want.kept[2], result_bus.kept_2);
                    check_field("kept_3", want.kept[3], result_bus.kept_3);
                    check_field("kept_4", want.kept[4], result_bus.kept_4);
                end
            end
            result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sample_bus.valid = 1'b0;
        sample_bus.clear = 1'b0;
        sample_bus.new_value = '0;
        result_bus.ready = 1'b0;
        error_count = 0;
        quiet_cycles = 0;
        shadow_fill = 0;
        foreach (shadow_slots[k])
            shadow_slots[k] = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Fill, duplicates, equal-to-smallest, drops and replacements at the extremes.
        push_sample(1'b1, 16'hFFFF);
        push_sample(1'b0, 16'h0000);
        push_sample(1'b0, 16'hFFFF);
        push_sample(1'b0, 16'h8000);
        push_sample(1'b0, 16'h8000);
        push_sample(1'b0, 16'h0001);
        push_sample(1'b0, 16'h0000);
        push_sample(1'b0, 16'h0002);
        push_sample(1'b0, 16'hFFFF);
        push_sample(1'b0, 16'h0001);
        push_sample(1'b1, 16'h1234);
        push_sample(1'b0, 16'hFFFF);
        push_sample(1'b0, 16'h5555);
        push_sample(1'b0, 16'hAAAA);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b1, 16'hFFFF);
        for (int v = 5; v >= 1; v--)
            push_sample(1'b0, value_t'(v));
        push_sample(1'b0, 16'h0003);
        push_sample(1'b0, 16'h0003);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
                1: begin sender_idle_pct = 69; receiver_stall_pct = 0; end
                2: begin sender_idle_pct = 0; receiver_stall_pct = 69; end
                default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_samples.push_back(random_sample());
            // Wait until the block has returned everything before the next phase.
            while (pending_samples.size() != 0 || sample_bus.valid ||
                   expected_views.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_views.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ top_five_tracker.f @@
+incdir+rtl
rtl/tft_pkg.sv
rtl/tft_if.sv
rtl/tft_update.sv
rtl/top_five_tracker.sv
test/top_five_tracker_tb.sv
